@@ hdl/prime_filter_trial_division_assert.svh @@
// Assertion macros shared by the checker of the prime filter.
`ifndef PRIME_FILTER_TRIAL_DIVISION_ASSERT_SVH
`define PRIME_FILTER_TRIAL_DIVISION_ASSERT_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is high.
`define PFTD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define PFTD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/pftd_pkg.sv @@
// Package of shared types and constants for the prime filter.
`timescale 1ns / 1ps

package pftd_pkg;

  // Default width of the value path.
  localparam int VALUE_WIDTH_DEFAULT = 16;

  // Number of entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Smallest prime, and so the first trial divisor.
  localparam int FIRST_DIVISOR = 2;

  // Fill status of the queue as seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // States of the trial division engine.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_EMIT
  } back_state_t;

endpackage

@@ hdl/pftd_front.sv @@
// Front end: accepts values and drops those that cannot be prime.
`timescale 1ns / 1ps

module pftd_front #(
  parameter int VALUE_WIDTH = pftd_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                      value_valid,
  output logic                      value_ready,
  input  logic [VALUE_WIDTH-1:0]    value,
  input  pftd_pkg::queue_status_t   status,
  output logic                      push,
  output logic [VALUE_WIDTH-1:0]    push_value
);

  logic below_first;

  // Zero and one are never prime, so they are consumed without a result.
  assign below_first = value < VALUE_WIDTH'(pftd_pkg::FIRST_DIVISOR);

  // A transaction is taken whenever the queue has room.
  assign value_ready = !status.full;
  assign push        = value_valid && value_ready && !below_first;
  assign push_value  = value;

endmodule

@@ hdl/pftd_queue.sv @@
// Short register queue that decouples the front end from the division engine.
`timescale 1ns / 1ps

module pftd_queue #(
  parameter int VALUE_WIDTH = pftd_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [VALUE_WIDTH-1:0]    push_value,
  input  logic                      pop,
  output logic [VALUE_WIDTH-1:0]    pop_value,
  output pftd_pkg::queue_status_t   status
);

  localparam int DEPTH = pftd_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [VALUE_WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]          wptr;
  logic [PW-1:0]          rptr;
  logic [CW-1:0]          count;

  assign status.full  = count == CW'(DEPTH);
  assign status.empty = count == '0;
  assign pop_value    = entries[rptr];

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_value;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ hdl/pftd_back.sv @@
// Division engine: trial division with a bit-serial remainder unit and an output register.
`timescale 1ns / 1ps

module pftd_back #(
  parameter int VALUE_WIDTH = pftd_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pftd_pkg::queue_status_t   status,
  input  logic [VALUE_WIDTH-1:0]    pop_value,
  output logic                      pop,
  output logic                      prime_value_valid,
  input  logic                      prime_value_ready,
  output logic [VALUE_WIDTH-1:0]    prime_value
);

  // Divisor width covers the square root bound plus one; the square is kept in full.
  localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int SW = 2 * DW;
  localparam int CW = $clog2(VALUE_WIDTH);

  pftd_pkg::back_state_t state, state_next;

  logic [VALUE_WIDTH-1:0] num,       num_next;
  logic [DW-1:0]          divisor,   divisor_next;
  logic [SW-1:0]          square,    square_next;
  logic [VALUE_WIDTH-1:0] shreg,     shreg_next;
  logic [DW-1:0]          rem,       rem_next;
  logic [CW-1:0]          bit_cnt,   bit_cnt_next;
  logic                   out_valid, out_valid_next;
  logic [VALUE_WIDTH-1:0] out_value, out_value_next;

  logic [DW:0]   trial;
  logic [DW-1:0] rem_step;
  logic          square_over;
  logic          out_free;

  // One restoring step of the remainder: bring in the next bit and subtract if it fits.
  always_comb begin
    trial = {rem, shreg[VALUE_WIDTH-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_step = DW'(trial - {1'b0, divisor});
    end else begin
      rem_step = trial[DW-1:0];
    end
  end

  assign square_over = square > {{(SW - VALUE_WIDTH){1'b0}}, num};
  assign out_free    = !out_valid || prime_value_ready;

  assign prime_value_valid = out_valid;
  assign prime_value       = out_value;

  // State register and control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pftd_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    num       <= num_next;
    divisor   <= divisor_next;
    square    <= square_next;
    shreg     <= shreg_next;
    rem       <= rem_next;
    bit_cnt   <= bit_cnt_next;
    out_value <= out_value_next;
  end

  // Next state and datapath control.
  always_comb begin
    state_next     = state;
    num_next       = num;
    divisor_next   = divisor;
    square_next    = square;
    shreg_next     = shreg;
    rem_next       = rem;
    bit_cnt_next   = bit_cnt;
    out_value_next = out_value;
    out_valid_next = out_valid && !prime_value_ready;
    pop            = 1'b0;

    unique case (state)
      pftd_pkg::ST_IDLE: begin
        if (!status.empty) begin
          pop          = 1'b1;
          num_next     = pop_value;
          divisor_next = DW'(pftd_pkg::FIRST_DIVISOR);
          square_next  = SW'(pftd_pkg::FIRST_DIVISOR * pftd_pkg::FIRST_DIVISOR);
          state_next   = pftd_pkg::ST_CHECK;
        end
      end
      pftd_pkg::ST_CHECK: begin
        // Past the square root bound with no divisor found: the value is prime.
        if (square_over) begin
          state_next = pftd_pkg::ST_EMIT;
        end else begin
          shreg_next   = num;
          rem_next     = '0;
          bit_cnt_next = CW'(VALUE_WIDTH - 1);
          state_next   = pftd_pkg::ST_DIVIDE;
        end
      end
      pftd_pkg::ST_DIVIDE: begin
        rem_next   = rem_step;
        shreg_next = {shreg[VALUE_WIDTH-2:0], 1'b0};
        if (bit_cnt == '0) begin
          if (rem_step == '0) begin
            // Divisor found: the value is composite and is dropped.
            state_next = pftd_pkg::ST_IDLE;
          end else begin
            divisor_next = divisor + DW'(1);
            square_next  = square + SW'({divisor, 1'b0}) + SW'(1);
            state_next   = pftd_pkg::ST_CHECK;
          end
        end else begin
          bit_cnt_next = bit_cnt - CW'(1);
        end
      end
      pftd_pkg::ST_EMIT: begin
        if (out_free) begin
          out_value_next = num;
          out_valid_next = 1'b1;
          state_next     = pftd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pftd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/prime_filter_trial_division.sv @@
// Top level of the prime filter: front end, queue and division engine.
`timescale 1ns / 1ps

// Passes on each input value that is prime and drops the rest; zero and one are
// dropped at once by the front end. Primality is decided by trial division with
// divisors from 2 upward while the divisor squared does not exceed the value,
// using one shared bit-serial remainder unit that steps through the value bit by
// bit for each divisor, after a square bound test. A prime that reaches the engine
// is passed on once the square of the next divisor exceeds it, and a composite is
// dropped as soon as its remainder by its smallest divisor is zero.
// A two-entry queue lets new transactions be accepted while the engine is busy,
// and the result register holds a finished prime while the engine moves on to
// the next value.
module prime_filter_trial_division #(
  parameter int VALUE_WIDTH = pftd_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   value_valid,
  output logic                   value_ready,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   prime_value_valid,
  input  logic                   prime_value_ready,
  output logic [VALUE_WIDTH-1:0] prime_value
);

  pftd_pkg::queue_status_t status;
  logic                   push;
  logic [VALUE_WIDTH-1:0] push_value;
  logic                   pop;
  logic [VALUE_WIDTH-1:0] pop_value;

  pftd_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .value_valid (value_valid),
    .value_ready (value_ready),
    .value       (value),
    .status      (status),
    .push        (push),
    .push_value  (push_value)
  );

  pftd_queue #(.VALUE_WIDTH(VALUE_WIDTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_value (push_value),
    .pop        (pop),
    .pop_value  (pop_value),
    .status     (status)
  );

  pftd_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk               (clk),
    .rst               (rst),
    .status            (status),
    .pop_value         (pop_value),
    .pop               (pop),
    .prime_value_valid (prime_value_valid),
    .prime_value_ready (prime_value_ready),
    .prime_value       (prime_value)
  );

endmodule

@@ hdl/pftd_checker.sv @@
// Port-level checker for the prime filter, bound to the top level.
`timescale 1ns / 1ps
`include "prime_filter_trial_division_assert.svh"

module pftd_checker #(
  parameter int VALUE_WIDTH = pftd_pkg::VALUE_WIDTH_DEFAULT
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   value_valid,
  input logic                   value_ready,
  input logic [VALUE_WIDTH-1:0] value,
  input logic                   prime_value_valid,
  input logic                   prime_value_ready,
  input logic [VALUE_WIDTH-1:0] prime_value
);

  localparam logic [VALUE_WIDTH-1:0] SMALLEST_PRIME = VALUE_WIDTH'(pftd_pkg::FIRST_DIVISOR);

  // An offered input stays offered, with the same value, until its transaction completes.
  `PFTD_ASSERT(a_in_hold, value_valid && !value_ready |=> value_valid && $stable(value), "input changed")

  // A result stays offered until its transaction completes.
  `PFTD_ASSERT(a_out_hold, prime_value_valid && !prime_value_ready |=> prime_value_valid, "result dropped")

  // A stalled result keeps its value.
  `PFTD_ASSERT(a_out_stable, prime_value_valid && !prime_value_ready |=> $stable(prime_value), "result changed")

  // Reset leaves no result on offer.
  `PFTD_ASSERT_ALWAYS(a_reset_clear, $past(rst) |-> !prime_value_valid, "result offered after reset")

  // Every prime above two is odd, so a result is odd or two.
  `PFTD_ASSERT(a_out_prime_shape, prime_value_valid |-> prime_value[0] || prime_value == SMALLEST_PRIME, "even result")

endmodule

bind prime_filter_trial_division pftd_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_pftd_checker (.*);
